// File: design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands, clocked on clk_i and disabled in reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising edge outside reset
`define ASSERT_CLK(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");

// condition must never be seen outside reset
`define ASSERT_NEVER(label, cond) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("forbidden condition seen");

`endif

// File: design/kvt_pkg.sv
// ----------------------------------------------------------------------------
// kvt_pkg
// Shared constants, command codes and broadcast bus type of the key/value table
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package kvt_pkg;

  localparam int DEPTH       = 16;
  localparam int KEY_WIDTH   = 32;
  localparam int VALUE_WIDTH = 32;
  localparam int CNT_W       = $clog2(DEPTH + 1);
  localparam int CAP_W       = 5;
  localparam int POS_W       = 4;
  localparam int CMD_W       = 3;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 3'd0,
    CMD_UPDATE = 3'd1,
    CMD_UPSERT = 3'd2,
    CMD_ERASE  = 3'd3,
    CMD_LOOKUP = 3'd4,
    CMD_READ   = 3'd5
  } cmd_e;

  // command broadcast from the controller to every cell
  typedef struct packed {
    logic [KEY_WIDTH-1:0]   key;
    logic [VALUE_WIDTH-1:0] value;
    logic [CNT_W-1:0]       count;
    logic [CNT_W-1:0]       pos;
    logic                   ins_en;
    logic                   upd_en;
    logic                   erase_en;
    logic                   lookup_en;
    logic                   read_en;
  } bcast_t;

endpackage

// File: design/kvt_cell.sv
// ----------------------------------------------------------------------------
// kvt_cell
// One table slot: holds a key/value pair, compares it against the broadcast
// key, passes the found flag and the selected data along the chain
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module kvt_cell (
  input  logic                            clk_i,
  input  logic [kvt_pkg::CNT_W-1:0]       idx_i,
  input  kvt_pkg::bcast_t                 bc_i,
  input  logic                            found_i,
  output logic                            found_o,
  input  logic [kvt_pkg::KEY_WIDTH-1:0]   nxt_key_i,
  input  logic [kvt_pkg::VALUE_WIDTH-1:0] nxt_val_i,
  output logic [kvt_pkg::KEY_WIDTH-1:0]   key_o,
  output logic [kvt_pkg::VALUE_WIDTH-1:0] val_o,
  input  logic [kvt_pkg::KEY_WIDTH-1:0]   acc_key_i,
  input  logic [kvt_pkg::VALUE_WIDTH-1:0] acc_val_i,
  output logic [kvt_pkg::KEY_WIDTH-1:0]   acc_key_o,
  output logic [kvt_pkg::VALUE_WIDTH-1:0] acc_val_o
);

  logic [kvt_pkg::KEY_WIDTH-1:0]   key_q, key_d;
  logic [kvt_pkg::VALUE_WIDTH-1:0] val_q, val_d;
  logic                            live;
  logic                            match;
  logic                            hit;
  logic                            rd_sel;

  assign live    = idx_i < bc_i.count;
  assign match   = live && (key_q == bc_i.key);
  assign hit     = match && !found_i;
  assign found_o = found_i || match;
  assign rd_sel  = bc_i.read_en && live && (idx_i == bc_i.pos);

  assign key_o = key_q;
  assign val_o = val_q;

  assign acc_key_o = acc_key_i | (rd_sel ? key_q : '0);
  assign acc_val_o = acc_val_i | ((rd_sel || (bc_i.lookup_en && hit)) ? val_q : '0);

  always_comb begin
    key_d = key_q;
    val_d = val_q;
    // erase: this slot and every later one pull from the upper neighbor
    if (bc_i.erase_en && (found_i || match)) begin
      key_d = nxt_key_i;
      val_d = nxt_val_i;
    end else if (bc_i.ins_en && (idx_i == bc_i.count)) begin
      key_d = bc_i.key;
      val_d = bc_i.value;
    end else if (bc_i.upd_en && hit) begin
      val_d = bc_i.value;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    val_q <= val_d;
  end

endmodule

// File: design/key_value_table_unit.sv
// ----------------------------------------------------------------------------
// key_value_table_unit
// Linear-search key/value table built as a chain of compare-and-shift cells
// ----------------------------------------------------------------------------
// Each command is accepted and its beat latched; the next cycle the whole
// cell chain searches, writes or shifts and the result is loaded into the
// output register. No new command is taken while one executes, nor while an
// untaken result waits on the output side; the result register frees the input side
// as soon as its beat is taken. Entries stay compacted in insertion order,
// erase shifts the later cells down one place in that same cycle, and insert
// fails once the count reaches the capacity register (saturated at the depth).
`timescale 1ns / 1ps

`include "assert_macros.svh"

module key_value_table_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [kvt_pkg::CAP_W-1:0]       cfg_wdata_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [kvt_pkg::CMD_W-1:0]       cmd_i,
  input  logic [kvt_pkg::KEY_WIDTH-1:0]   key_i,
  input  logic [kvt_pkg::VALUE_WIDTH-1:0] value_i,
  input  logic [kvt_pkg::POS_W-1:0]       position_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic                            ok_o,
  output logic [kvt_pkg::KEY_WIDTH-1:0]   key_out_o,
  output logic [kvt_pkg::VALUE_WIDTH-1:0] value_out_o,
  output logic [kvt_pkg::CNT_W-1:0]       count_o
);

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_e;

  state_e                          state_q;
  logic [kvt_pkg::CAP_W-1:0]       capacity_q;
  logic [kvt_pkg::CNT_W-1:0]       count_q, count_d;
  logic [kvt_pkg::CMD_W-1:0]       cmd_q;
  logic [kvt_pkg::KEY_WIDTH-1:0]   key_q;
  logic [kvt_pkg::VALUE_WIDTH-1:0] value_q;
  logic [kvt_pkg::POS_W-1:0]       pos_q;

  logic                            out_valid_q;
  logic                            ok_q, ok_d;
  logic [kvt_pkg::KEY_WIDTH-1:0]   key_out_q;
  logic [kvt_pkg::VALUE_WIDTH-1:0] value_out_q;
  logic [kvt_pkg::CNT_W-1:0]       count_out_q;

  logic [kvt_pkg::CNT_W-1:0]       limit;
  logic                            has_room;
  logic                            any_hit;
  logic                            exec;
  logic                            in_fire;
  kvt_pkg::bcast_t                 bc;

  logic                            found_c [kvt_pkg::DEPTH+1];
  logic [kvt_pkg::KEY_WIDTH-1:0]   acc_key_c [kvt_pkg::DEPTH+1];
  logic [kvt_pkg::VALUE_WIDTH-1:0] acc_val_c [kvt_pkg::DEPTH+1];
  logic [kvt_pkg::KEY_WIDTH-1:0]   cell_key [kvt_pkg::DEPTH];
  logic [kvt_pkg::VALUE_WIDTH-1:0] cell_val [kvt_pkg::DEPTH];

  assign exec       = (state_q == ST_EXEC);
  assign in_ready_o = (state_q == ST_IDLE) && (!out_valid_q || out_ready_i);
  assign in_fire    = in_valid_i && in_ready_o;

  assign limit = (capacity_q > kvt_pkg::CAP_W'(kvt_pkg::DEPTH)) ?
                 kvt_pkg::CNT_W'(kvt_pkg::DEPTH) : kvt_pkg::CNT_W'(capacity_q);
  assign has_room = count_q < limit;
  assign any_hit  = found_c[kvt_pkg::DEPTH];

  // broadcast; write enables only fire in the execute cycle
  always_comb begin
    bc           = '0;
    bc.key       = key_q;
    bc.value     = value_q;
    bc.count     = count_q;
    bc.pos       = kvt_pkg::CNT_W'(pos_q);
    bc.lookup_en = (cmd_q == kvt_pkg::CMD_LOOKUP);
    bc.read_en   = (cmd_q == kvt_pkg::CMD_READ);
    bc.upd_en    = exec && ((cmd_q == kvt_pkg::CMD_UPDATE) || (cmd_q == kvt_pkg::CMD_UPSERT));
    bc.erase_en  = exec && (cmd_q == kvt_pkg::CMD_ERASE) && any_hit;
    bc.ins_en    = exec && ((cmd_q == kvt_pkg::CMD_INSERT) || (cmd_q == kvt_pkg::CMD_UPSERT))
                   && !any_hit && has_room;
  end

  assign found_c[0]   = 1'b0;
  assign acc_key_c[0] = '0;
  assign acc_val_c[0] = '0;

  for (genvar i = 0; i < kvt_pkg::DEPTH; i++) begin : g_cell
    logic [kvt_pkg::KEY_WIDTH-1:0]   nxt_key;
    logic [kvt_pkg::VALUE_WIDTH-1:0] nxt_val;

    // top cell pulls its own contents; it falls out of the count anyway
    if (i == kvt_pkg::DEPTH - 1) begin : g_top
      assign nxt_key = cell_key[i];
      assign nxt_val = cell_val[i];
    end else begin : g_mid
      assign nxt_key = cell_key[i+1];
      assign nxt_val = cell_val[i+1];
    end

    kvt_cell u_cell (
      .clk_i     (clk_i),
      .idx_i     (kvt_pkg::CNT_W'(i)),
      .bc_i      (bc),
      .found_i   (found_c[i]),
      .found_o   (found_c[i+1]),
      .nxt_key_i (nxt_key),
      .nxt_val_i (nxt_val),
      .key_o     (cell_key[i]),
      .val_o     (cell_val[i]),
      .acc_key_i (acc_key_c[i]),
      .acc_val_i (acc_val_c[i]),
      .acc_key_o (acc_key_c[i+1]),
      .acc_val_o (acc_val_c[i+1])
    );
  end

  always_comb begin
    case (cmd_q)
      kvt_pkg::CMD_INSERT: ok_d = !any_hit && has_room;
      kvt_pkg::CMD_UPDATE: ok_d = any_hit;
      kvt_pkg::CMD_UPSERT: ok_d = any_hit || has_room;
      kvt_pkg::CMD_ERASE:  ok_d = any_hit;
      kvt_pkg::CMD_LOOKUP: ok_d = any_hit;
      kvt_pkg::CMD_READ:   ok_d = kvt_pkg::CNT_W'(pos_q) < count_q;
      default:             ok_d = 1'b0;
    endcase
  end

  always_comb begin
    count_d = count_q;
    if (bc.ins_en) begin
      count_d = count_q + kvt_pkg::CNT_W'(1);
    end else if (bc.erase_en) begin
      count_d = count_q - kvt_pkg::CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      count_q     <= '0;
      capacity_q  <= kvt_pkg::CAP_W'(16);
    end else begin
      if (cfg_we_i) begin
        capacity_q <= cfg_wdata_i;
      end
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            state_q <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          state_q     <= ST_IDLE;
          out_valid_q <= 1'b1;
          count_q     <= count_d;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      cmd_q   <= cmd_i;
      key_q   <= key_i;
      value_q <= value_i;
      pos_q   <= position_i;
    end
    if (exec) begin
      ok_q        <= ok_d;
      key_out_q   <= acc_key_c[kvt_pkg::DEPTH];
      value_out_q <= acc_val_c[kvt_pkg::DEPTH];
      count_out_q <= count_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign ok_o        = ok_q;
  assign key_out_o   = key_out_q;
  assign value_out_o = value_out_q;
  assign count_o     = count_out_q;

  `ASSERT_NEVER(a_count_range, count_q > kvt_pkg::CNT_W'(kvt_pkg::DEPTH))
  `ASSERT_CLK(a_count_only_exec, (count_q != $past(count_q)) |-> $past(state_q == ST_EXEC))
  `ASSERT_CLK(a_result_after_exec, $rose(out_valid_q) |-> $past(state_q == ST_EXEC))
  `ASSERT_NEVER(a_exec_needs_free_out, exec && out_valid_q)

endmodule
